// File: rtl/u2c_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u2c_pkg: shared types and tables of the utf-8 to code page 437 converter
// holds the queue entry format, lead byte classes and the glyph table
// ----------------------------------------------------------------------------
package u2c_pkg;

  localparam int PointW     = 21;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCountW    = $clog2(QueueDepth + 1);

  localparam logic [7:0] QMark = 8'h3F;

  // lead byte class masks and patterns
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Pat  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Pat  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Pat  = 8'hF0;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContPat   = 8'h80;

  // one queue entry: a run of '?' words, then an optional mapped code point
  typedef struct packed {
    logic [1:0]        nq;
    logic              tail;
    logic [PointW-1:0] point;
  } u2c_item_t;

  // decoder state seen by the checks
  typedef struct packed {
    logic [1:0] needed;
    logic [1:0] taken;
  } u2c_front_stat_t;

  function automatic logic [7:0] u2c_map(input logic [PointW-1:0] cp);
    logic [7:0] g;
    g = QMark;
    if (cp < PointW'(8'h80)) begin
      g = cp[7:0];
    end else begin
      case (cp)
        21'h00E0: g = 8'h85;  21'h00E1: g = 8'hA0;  21'h00E2: g = 8'h83;
        21'h00E3: g = 8'h84;  21'h00E4: g = 8'h84;  21'h00E5: g = 8'h86;
        21'h00E6: g = 8'h91;  21'h00E7: g = 8'h87;  21'h00E8: g = 8'h8A;
        21'h00E9: g = 8'h82;  21'h00EA: g = 8'h88;  21'h00EB: g = 8'h89;
        21'h00EC: g = 8'h8D;  21'h00ED: g = 8'hA1;  21'h00EE: g = 8'h8C;
        21'h00EF: g = 8'h8B;  21'h00F1: g = 8'hA4;  21'h00F2: g = 8'h95;
        21'h00F3: g = 8'hA2;  21'h00F4: g = 8'h93;  21'h00F5: g = 8'h94;
        21'h00F6: g = 8'h94;  21'h00F9: g = 8'h97;  21'h00FA: g = 8'hA3;
        21'h00FB: g = 8'h96;  21'h00FC: g = 8'h81;
        21'h00C0: g = 8'h41;  21'h00C1: g = 8'h41;  21'h00C2: g = 8'h41;
        21'h00C3: g = 8'h41;  21'h00C4: g = 8'h8E;  21'h00C5: g = 8'h8F;
        21'h00C6: g = 8'h92;  21'h00C7: g = 8'h80;  21'h00C8: g = 8'h45;
        21'h00C9: g = 8'h90;  21'h00CA: g = 8'h45;  21'h00CB: g = 8'h45;
        21'h00CC: g = 8'h49;  21'h00CD: g = 8'h49;  21'h00CE: g = 8'h49;
        21'h00CF: g = 8'h49;  21'h00D1: g = 8'hA5;  21'h00D2: g = 8'h4F;
        21'h00D3: g = 8'h4F;  21'h00D4: g = 8'h4F;  21'h00D5: g = 8'h4F;
        21'h00D6: g = 8'h99;  21'h00D9: g = 8'h55;  21'h00DA: g = 8'h55;
        21'h00DB: g = 8'h55;  21'h00DC: g = 8'h9A;
        21'h00A1: g = 8'hAD;  21'h00A2: g = 8'h9B;  21'h00A3: g = 8'h9C;
        21'h00A5: g = 8'h9D;  21'h00AA: g = 8'hA6;  21'h00AB: g = 8'hAE;
        21'h00AC: g = 8'hAA;  21'h00B0: g = 8'hF8;  21'h00B1: g = 8'hF1;
        21'h00B2: g = 8'hFD;  21'h00B5: g = 8'hE6;  21'h00B7: g = 8'hFA;
        21'h00BA: g = 8'hA7;  21'h00BB: g = 8'hAF;  21'h00BC: g = 8'hAC;
        21'h00BD: g = 8'hAB;  21'h00BF: g = 8'hA8;  21'h00D7: g = 8'h78;
        21'h00DF: g = 8'hE1;  21'h00F7: g = 8'hF6;
        21'h2500: g = 8'hC4;  21'h2502: g = 8'hB3;  21'h250C: g = 8'hDA;
        21'h2510: g = 8'hBF;  21'h2514: g = 8'hC0;  21'h2518: g = 8'hD9;
        21'h251C: g = 8'hC3;  21'h2524: g = 8'hB4;  21'h252C: g = 8'hC2;
        21'h2534: g = 8'hC1;  21'h253C: g = 8'hC5;
        21'h2550: g = 8'hCD;  21'h2551: g = 8'hBA;  21'h2554: g = 8'hC9;
        21'h2557: g = 8'hBB;  21'h255A: g = 8'hC8;  21'h255D: g = 8'hBC;
        21'h2560: g = 8'hCC;  21'h2563: g = 8'hB9;  21'h2566: g = 8'hCB;
        21'h2569: g = 8'hCA;  21'h256C: g = 8'hCE;
        21'h2552: g = 8'hD5;  21'h2553: g = 8'hD6;  21'h2555: g = 8'hB8;
        21'h2556: g = 8'hB7;  21'h2558: g = 8'hD4;  21'h2559: g = 8'hD3;
        21'h255B: g = 8'hBE;  21'h255C: g = 8'hBD;  21'h255E: g = 8'hC6;
        21'h255F: g = 8'hC7;  21'h2561: g = 8'hB5;  21'h2562: g = 8'hB6;
        21'h2564: g = 8'hD1;  21'h2565: g = 8'hD2;  21'h2567: g = 8'hCF;
        21'h2568: g = 8'hD0;
        21'h2588: g = 8'hDB;  21'h2591: g = 8'hB0;  21'h2592: g = 8'hB1;
        21'h2593: g = 8'hB2;  21'h2580: g = 8'hDF;  21'h2584: g = 8'hDC;
        21'h258C: g = 8'hDD;  21'h2590: g = 8'hDE;
        21'h2190: g = 8'h1B;  21'h2191: g = 8'h18;  21'h2192: g = 8'h1A;
        21'h2193: g = 8'h19;  21'h2194: g = 8'h1D;  21'h2195: g = 8'h12;
        21'h0393: g = 8'hE2;  21'h0398: g = 8'hE9;  21'h03A3: g = 8'hE4;
        21'h03A6: g = 8'hE8;  21'h03A9: g = 8'hEA;  21'h03B1: g = 8'hE0;
        21'h03B4: g = 8'hEB;  21'h03B5: g = 8'hEE;  21'h03C0: g = 8'hE3;
        21'h03C3: g = 8'hE5;  21'h03C4: g = 8'hE7;  21'h03C6: g = 8'hED;
        21'h2219: g = 8'hF9;  21'h221A: g = 8'hFB;  21'h221E: g = 8'hEC;
        21'h2229: g = 8'hEF;  21'h2248: g = 8'hF7;  21'h2260: g = 8'hF0;
        21'h2261: g = 8'hF0;  21'h2264: g = 8'hF3;  21'h2265: g = 8'hF2;
        21'h263A: g = 8'h01;  21'h263B: g = 8'h02;  21'h2665: g = 8'h03;
        21'h2666: g = 8'h04;  21'h2663: g = 8'h05;  21'h2660: g = 8'h06;
        21'h2022: g = 8'h07;  21'h25CB: g = 8'h09;  21'h266A: g = 8'h0D;
        21'h266B: g = 8'h0E;  21'h25BA: g = 8'h10;  21'h25C4: g = 8'h11;
        21'h25B2: g = 8'h1E;  21'h25BC: g = 8'h1F;
        default:  g = QMark;
      endcase
    end
    return g;
  endfunction

endpackage
`default_nettype wire

// File: rtl/utf8_to_cp437_converter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_cp437_converter_unit: utf-8 byte stream to code page 437 glyphs
// decoder front, small entry queue and registered word emitter
// ----------------------------------------------------------------------------
// usage
//   input channel: in_byte with in_valid / in_stall, one utf-8 byte per word
//   output channel: glyph and run_end with out_valid / out_stall
//   a byte is decoded in the cycle it is taken; its first result word
//   reaches the output through the queue and then the output register
//   each input byte gives zero to four words; run_end marks the last one
//   words per cycle: one, set by the single output register, so plain
//   ascii and completed sequences flow at one byte per cycle while
//   out_stall is low; a broken sequence gives its '?' words one by one
//   the four-entry queue fills while the output is stalled or emitting a
//   burst; in_stall rises only when the queue is full
//   a stalled output word holds until taken
//   reset empties the queue, drops any pending sequence and clears
//   out_valid; no clearing pass is needed
// ----------------------------------------------------------------------------
module utf8_to_cp437_converter_unit
  import u2c_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      glyph,
  output logic            run_end
);

  u2c_item_t        item;
  u2c_item_t        head;
  u2c_front_stat_t  stat;
  logic             accept;
  logic             push;
  logic             pop;
  logic             q_empty;
  logic             q_full;

  // stall only on a full queue, so the front keeps taking bytes
  // while the emitter waits on the receiver
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // front: classify the byte, update the pending sequence
  u2c_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .item    (item),
    .push    (push),
    .stat    (stat)
  );

  // queue between decoder and emitter
  u2c_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (item),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  // back: one word per cycle into the output register while the output is not stalled
  u2c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .glyph     (glyph),
    .run_end   (run_end)
  );

  // retiring an entry always leaves its last word on the output
  a_pop_marks_end : assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid && run_end)
    else $error("entry retired without a run_end word");

  // no continuation count without a pending sequence
  a_idle_no_taken : assert property (@(posedge clk) disable iff (rst)
    stat.needed == 2'd0 |-> stat.taken == 2'd0)
    else $error("continuation count left over while idle");

  // taken plus still needed never exceeds a four-byte sequence
  a_seq_bound : assert property (@(posedge clk) disable iff (rst)
    ({1'b0, stat.needed} + {1'b0, stat.taken}) <= 3'd3)
    else $error("sequence length out of range");

endmodule
`default_nettype wire

// File: rtl/u2c_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u2c_front: utf-8 sequence decoder
// tracks the pending code point and turns each byte into at most one queue entry
// ----------------------------------------------------------------------------
module u2c_front
  import u2c_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      in_byte,
  output u2c_item_t            item,
  output logic                 push,
  output u2c_front_stat_t      stat
);

  logic [PointW-1:0] partial_point, partial_point_next;
  logic [1:0]        bytes_needed, bytes_needed_next;
  logic [1:0]        bytes_taken, bytes_taken_next;
  logic [PointW-1:0] grown;
  logic              lead;

  assign grown = {partial_point[PointW-7:0], in_byte[5:0]};

  always_comb begin
    item               = '0;
    partial_point_next = partial_point;
    bytes_needed_next  = bytes_needed;
    bytes_taken_next   = bytes_taken;
    lead               = 1'b0;

    if (bytes_needed == 2'd0) begin
      lead = 1'b1;
    end else if ((in_byte & ContMask) == ContPat) begin
      partial_point_next = grown;
      bytes_needed_next  = bytes_needed - 2'd1;
      bytes_taken_next   = bytes_taken + 2'd1;
      if (bytes_needed == 2'd1) begin
        item.tail          = 1'b1;
        item.point         = grown;
        partial_point_next = '0;
        bytes_taken_next   = 2'd0;
      end
    end else begin
      // broken sequence: one '?' for the lead and each continuation so far
      item.nq            = bytes_taken + 2'd1;
      partial_point_next = '0;
      bytes_needed_next  = 2'd0;
      bytes_taken_next   = 2'd0;
      lead               = 1'b1;
    end

    if (lead) begin
      if (in_byte == 8'h00) begin
        // end of string, nothing more
      end else if (!in_byte[7]) begin
        item.tail  = 1'b1;
        item.point = PointW'(in_byte);
      end else if ((in_byte & Lead2Mask) == Lead2Pat) begin
        partial_point_next = PointW'(in_byte[4:0]);
        bytes_needed_next  = 2'd1;
        bytes_taken_next   = 2'd0;
      end else if ((in_byte & Lead3Mask) == Lead3Pat) begin
        partial_point_next = PointW'(in_byte[3:0]);
        bytes_needed_next  = 2'd2;
        bytes_taken_next   = 2'd0;
      end else if ((in_byte & Lead4Mask) == Lead4Pat) begin
        partial_point_next = PointW'(in_byte[2:0]);
        bytes_needed_next  = 2'd3;
        bytes_taken_next   = 2'd0;
      end else begin
        item.tail  = 1'b1;
        item.point = PointW'(QMark);
      end
    end
  end

  assign push = accept && (item.nq != 2'd0 || item.tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_point <= '0;
      bytes_needed  <= 2'd0;
      bytes_taken   <= 2'd0;
    end else if (accept) begin
      partial_point <= partial_point_next;
      bytes_needed  <= bytes_needed_next;
      bytes_taken   <= bytes_taken_next;
    end
  end

  assign stat.needed = bytes_needed;
  assign stat.taken  = bytes_taken;

endmodule
`default_nettype wire

// File: rtl/u2c_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u2c_queue: short fifo of decoded entries
// decouples the decoder from the word emitter
// ----------------------------------------------------------------------------
module u2c_queue
  import u2c_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire u2c_item_t wr_item,
  input  wire logic      pop,
  output u2c_item_t      head,
  output logic           empty,
  output logic           full
);

  u2c_item_t            slots [QueueDepth];
  logic [QPtrW-1:0]     wr_ptr;
  logic [QPtrW-1:0]     rd_ptr;
  logic [QCountW-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == QCountW'(QueueDepth));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      if (push && !pop) begin
        count <= count + QCountW'(1);
      end else if (pop && !push) begin
        count <= count - QCountW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/u2c_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u2c_back: word emitter
// walks the head entry word by word into a registered output stage
// ----------------------------------------------------------------------------
module u2c_back
  import u2c_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire u2c_item_t  head,
  input  wire logic       empty,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      glyph,
  output logic            run_end
);

  logic [1:0] idx;
  logic       load;
  logic       last;
  logic [7:0] word;

  always_comb begin
    if (idx < head.nq) begin
      word = QMark;
      last = (idx == head.nq - 2'd1) && !head.tail;
    end else begin
      word = u2c_map(head.point);
      last = 1'b1;
    end
  end

  assign load = !out_valid || !out_stall;
  assign pop  = load && !empty && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        idx <= last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      glyph   <= word;
      run_end <= last;
    end
  end

endmodule
`default_nettype wire

// File: dv/utf8_to_cp437_converter_unit_tb.sv
// ----------------------------------------------------------------------------
// utf8_to_cp437_converter_unit_tb: self-checking bench for the utf-8 decoder
// drives utf-8 byte streams (clean text, overlong forms, broken and truncated
// sequences, random noise), predicts the code page 437 words and run_end
// marks of each byte, and checks every word taken from the output channel
// ----------------------------------------------------------------------------
module utf8_to_cp437_converter_unit_tb;
  import u2c_pkg::*;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned MapSize       = 159;

  // one predicted output word
  typedef struct packed {
    logic [7:0] cp437;
    logic       last_word;
  } glyph_exp_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] glyph;
  logic       run_end;

  utf8_to_cp437_converter_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .glyph     (glyph),
    .run_end   (run_end)
  );

  // code points known to the code page, with the glyph each one maps to
  logic [20:0] map_pts [MapSize] = '{
    'h00E0, 'h00E1, 'h00E2, 'h00E3, 'h00E4, 'h00E5, 'h00E6, 'h00E7, 'h00E8, 'h00E9,
    'h00EA, 'h00EB, 'h00EC, 'h00ED, 'h00EE, 'h00EF, 'h00F1, 'h00F2, 'h00F3, 'h00F4,
    'h00F5, 'h00F6, 'h00F9, 'h00FA, 'h00FB, 'h00FC,
    'h00C0, 'h00C1, 'h00C2, 'h00C3, 'h00C4, 'h00C5, 'h00C6, 'h00C7, 'h00C8, 'h00C9,
    'h00CA, 'h00CB, 'h00CC, 'h00CD, 'h00CE, 'h00CF, 'h00D1, 'h00D2, 'h00D3, 'h00D4,
    'h00D5, 'h00D6, 'h00D9, 'h00DA, 'h00DB, 'h00DC,
    'h00A1, 'h00A2, 'h00A3, 'h00A5, 'h00AA, 'h00AB, 'h00AC, 'h00B0, 'h00B1, 'h00B2,
    'h00B5, 'h00B7, 'h00BA, 'h00BB, 'h00BC, 'h00BD, 'h00BF, 'h00D7, 'h00DF, 'h00F7,
    'h2500, 'h2502, 'h250C, 'h2510, 'h2514, 'h2518, 'h251C, 'h2524, 'h252C, 'h2534,
    'h253C,
    'h2550, 'h2551, 'h2554, 'h2557, 'h255A, 'h255D, 'h2560, 'h2563, 'h2566, 'h2569,
    'h256C,
    'h2552, 'h2553, 'h2555, 'h2556, 'h2558, 'h2559, 'h255B, 'h255C, 'h255E, 'h255F,
    'h2561, 'h2562, 'h2564, 'h2565, 'h2567, 'h2568,
    'h2588, 'h2591, 'h2592, 'h2593, 'h2580, 'h2584, 'h258C, 'h2590,
    'h2190, 'h2191, 'h2192, 'h2193, 'h2194, 'h2195,
    'h0393, 'h0398, 'h03A3, 'h03A6, 'h03A9, 'h03B1, 'h03B4, 'h03B5, 'h03C0, 'h03C3,
    'h03C4, 'h03C6, 'h2219, 'h221A, 'h221E, 'h2229, 'h2248, 'h2260, 'h2261, 'h2264,
    'h2265,
    'h263A, 'h263B, 'h2665, 'h2666, 'h2663, 'h2660, 'h2022, 'h25CB, 'h266A, 'h266B,
    'h25BA, 'h25C4, 'h25B2, 'h25BC
  };

  logic [7:0] map_glyphs [MapSize] = '{
    'h85, 'hA0, 'h83, 'h84, 'h84, 'h86, 'h91, 'h87, 'h8A, 'h82,
    'h88, 'h89, 'h8D, 'hA1, 'h8C, 'h8B, 'hA4, 'h95, 'hA2, 'h93,
    'h94, 'h94, 'h97, 'hA3, 'h96, 'h81,
    'h41, 'h41, 'h41, 'h41, 'h8E, 'h8F, 'h92, 'h80, 'h45, 'h90,
    'h45, 'h45, 'h49, 'h49, 'h49, 'h49, 'hA5, 'h4F, 'h4F, 'h4F,
    'h4F, 'h99, 'h55, 'h55, 'h55, 'h9A,
    'hAD, 'h9B, 'h9C, 'h9D, 'hA6, 'hAE, 'hAA, 'hF8, 'hF1, 'hFD,
    'hE6, 'hFA, 'hA7, 'hAF, 'hAC, 'hAB, 'hA8, 'h78, 'hE1, 'hF6,
    'hC4, 'hB3, 'hDA, 'hBF, 'hC0, 'hD9, 'hC3, 'hB4, 'hC2, 'hC1,
    'hC5,
    'hCD, 'hBA, 'hC9, 'hBB, 'hC8, 'hBC, 'hCC, 'hB9, 'hCB, 'hCA,
    'hCE,
    'hD5, 'hD6, 'hB8, 'hB7, 'hD4, 'hD3, 'hBE, 'hBD, 'hC6, 'hC7,
    'hB5, 'hB6, 'hD1, 'hD2, 'hCF, 'hD0,
    'hDB, 'hB0, 'hB1, 'hB2, 'hDF, 'hDC, 'hDD, 'hDE,
    'h1B, 'h18, 'h1A, 'h19, 'h1D, 'h12,
    'hE2, 'hE9, 'hE4, 'hE8, 'hEA, 'hE0, 'hEB, 'hEE, 'hE3, 'hE5,
    'hE7, 'hED, 'hF9, 'hFB, 'hEC, 'hEF, 'hF7, 'hF0, 'hF0, 'hF3,
    'hF2,
    'h01, 'h02, 'h03, 'h04, 'h05, 'h06, 'h07, 'h09, 'h0D, 'h0E,
    'h10, 'h11, 'h1E, 'h1F
  };

  // words still owed by the block, oldest first
  glyph_exp_t  glyph_q [$];
  glyph_exp_t  head_exp;

  // decoder state mirrored by the predictor
  logic [20:0] acc_point;
  logic [1:0]  need_cnt;
  logic [1:0]  taken_cnt;
  int unsigned step_words;

  int unsigned err_count;
  int unsigned items_sent;
  int unsigned idle_cycles;

  // idling controls for the sender and the receiver
  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned hold_left;
  int unsigned stall_left;

  // ---------------------------------------------------------------------------
  // clock and idling helpers
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] cp437_of(input logic [20:0] cp);
    if (cp < 21'h80) return cp[7:0];
    for (int i = 0; i < MapSize; i++) begin
      if (map_pts[i] == cp) return map_glyphs[i];
    end
    return QMark;
  endfunction

  function automatic void push_glyph(input logic [7:0] g);
    glyph_exp_t w;
    w.cp437     = g;
    w.last_word = 1'b0;
    glyph_q.push_back(w);
    step_words++;
  endfunction

  // a byte seen with no sequence pending
  function automatic void take_lead_byte(input logic [7:0] b);
    if (b == 8'h00) return;              // end of string while idle: nothing
    if (!b[7]) begin
      push_glyph(b);                     // plain ascii
    end else if ((b & Lead2Mask) == Lead2Pat) begin
      acc_point = 21'(b & 8'h1F);
      need_cnt  = 2'd1;
      taken_cnt = 2'd0;
    end else if ((b & Lead3Mask) == Lead3Pat) begin
      acc_point = 21'(b & 8'h0F);
      need_cnt  = 2'd2;
      taken_cnt = 2'd0;
    end else if ((b & Lead4Mask) == Lead4Pat) begin
      acc_point = 21'(b & 8'h07);
      need_cnt  = 2'd3;
      taken_cnt = 2'd0;
    end else begin
      push_glyph(QMark);                 // stray continuation or 0xf8..0xff
    end
  endfunction

  // works out the words one accepted byte causes and queues them
  function automatic void predict_glyphs(input logic [7:0] b);
    glyph_exp_t w;
    step_words = 0;
    if (need_cnt == 2'd0) begin
      take_lead_byte(b);
    end else if ((b & ContMask) == ContPat) begin
      acc_point = {acc_point[14:0], b[5:0]};
      taken_cnt = taken_cnt + 2'd1;
      need_cnt  = need_cnt - 2'd1;
      if (need_cnt == 2'd0) begin
        push_glyph(cp437_of(acc_point));
        acc_point = '0;
        taken_cnt = 2'd0;
      end
    end else begin
      // broken sequence: one '?' for the lead and one per continuation taken,
      // then the offending byte starts over as a lead (a zero just ends)
      for (int k = 0; k <= int'(taken_cnt) && k < 3; k++) push_glyph(QMark);
      acc_point = '0;
      need_cnt  = 2'd0;
      taken_cnt = 2'd0;
      take_lead_byte(b);
    end
    if (step_words > 0) begin
      w = glyph_q.pop_back();
      w.last_word = 1'b1;
      glyph_q.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  // offers one byte, optionally after a gap, and returns just after the edge
  // that took it; valid stays high so back-to-back words need no toggle
  task automatic send_word(input logic [7:0] b);
    int unsigned gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_glyphs(b);
    items_sent++;
  endtask

  // encodes a code point in len bytes (longer than needed gives an overlong form)
  task automatic send_point(input logic [20:0] cp, input int unsigned len);
    case (len)
      1: send_word({1'b0, cp[6:0]});
      2: begin
        send_word({3'b110, cp[10:6]});
        send_word({2'b10, cp[5:0]});
      end
      3: begin
        send_word({4'b1110, cp[15:12]});
        send_word({2'b10, cp[11:6]});
        send_word({2'b10, cp[5:0]});
      end
      default: begin
        send_word({5'b11110, cp[20:18]});
        send_word({2'b10, cp[17:12]});
        send_word({2'b10, cp[11:6]});
        send_word({2'b10, cp[5:0]});
      end
    endcase
  endtask

  function automatic int unsigned min_len(input logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // any byte that cannot continue a sequence
  function automatic logic [7:0] pick_breaker();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while ((b & ContMask) == ContPat);
    return b;
  endfunction

  // lowers valid and waits until every owed word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (glyph_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus long hold-offs asked for by a test
  // ---------------------------------------------------------------------------
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (rx_idle_on && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checker
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (err_count < 20) $display("mismatch @%0t: %s", $time, msg);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (glyph_q.size() == 0) begin
        report_mismatch($sformatf("word with nothing owed: glyph=%02h run_end=%0b",
                                  glyph, run_end));
      end else begin
        head_exp = glyph_q.pop_front();
        if (glyph !== head_exp.cp437)
          report_mismatch($sformatf("glyph %02h, want %02h", glyph, head_exp.cp437));
        if (run_end !== head_exp.last_word)
          report_mismatch($sformatf("run_end %0b, want %0b (glyph %02h)",
                                    run_end, head_exp.last_word, head_exp.cp437));
      end
    end
  end

  // watchdog: too long with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no word moved for %0d cycles", idle_cycles);
        $display("** utf8_to_cp437_converter_unit: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // byte extremes and every special case of the decoder
  task automatic test_directed();
    logic [7:0] seq [$];
    seq = '{
      8'h00,                        // end of string while idle
      8'h7F, 8'h80, 8'hFF,          // top ascii, stray continuation, bad lead
      8'hC3, 8'hA9,                 // two-byte letter in the table
      8'hE2, 8'h95, 8'h94,          // three-byte box drawing
      8'hF0, 8'h9F, 8'h98, 8'h80,   // four-byte, not in the table
      8'hC0, 8'h80,                 // overlong zero decodes to zero
      8'hE2, 8'h95, 8'h41,          // broken after one continuation, ascii restarts
      8'hF0, 8'h9F, 8'h00,          // end of string with a sequence pending
      8'hF0, 8'h80, 8'h80, 8'hFF,   // broken late by a bad lead: four words
      8'hC3, 8'hC3, 8'hA9           // broken by a new lead that then completes
    };
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    foreach (seq[i]) send_word(seq[i]);
  endtask

  // well-formed text: ascii, table entries, random code points, overlong forms
  task automatic test_text_stream(input int unsigned n_bytes, input bit idle);
    int unsigned stop_at;
    int unsigned r;
    int unsigned len;
    logic [20:0] cp;
    tx_idle_on = idle;
    rx_idle_on = idle;
    stop_at    = items_sent + n_bytes;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        cp  = 21'($urandom_range(0, 'h7F));
        len = 1;
      end else if (r < 70) begin
        cp  = map_pts[$urandom_range(0, MapSize - 1)];
        len = min_len(cp);
      end else if (r < 88) begin
        len = $urandom_range(2, 4);
        case (len)
          2:       cp = 21'($urandom_range('h80, 'h7FF));
          3:       cp = 21'($urandom_range('h800, 'hFFFF));
          default: cp = 21'($urandom_range('h10000, 'h1FFFFF));
        endcase
      end else begin
        // overlong: a short value stretched to a longer encoding
        cp  = (r < 94) ? 21'($urandom_range(0, 'h7F)) : map_pts[$urandom_range(0, 51)];
        len = $urandom_range(min_len(cp) + 1, 4);
      end
      send_point(cp, len);
    end
  endtask

  // raw bytes, two-byte code points and sequences cut short by a foreign byte or end of string
  task automatic test_noise(input int unsigned n_rounds);
    int unsigned len;
    int unsigned n_cont;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (n_rounds) begin
      case ($urandom_range(0, 2))
        0: send_word(8'($urandom_range(0, 255)));
        1: begin
          len    = $urandom_range(2, 4);
          n_cont = $urandom_range(0, len - 2);
          case (len)
            2:       send_word({3'b110, 5'($urandom)});
            3:       send_word({4'b1110, 4'($urandom)});
            default: send_word({5'b11110, 3'($urandom)});
          endcase
          repeat (n_cont) send_word({2'b10, 6'($urandom)});
          send_word(($urandom_range(0, 3) == 0) ? 8'h00 : pick_breaker());
        end
        default: send_point(21'($urandom_range(0, 'h7FF)), 2);
      endcase
    end
  endtask

  // receiver holds off a long while as the sender keeps offering bytes,
  // so the queue fills and in_stall must rise
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_left  = 200;
    repeat (30) send_word(8'($urandom_range('h20, 'h7E)));
    // bursts of '?' words against a second hold-off
    hold_left = 120;
    repeat (3) begin
      send_word(8'hF0);
      send_word(8'h80);
      send_word(8'h80);
      send_word(8'hFF);
    end
  endtask

  // sender goes quiet until everything owed has come back, a few times over
  task automatic test_drain_pause();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (3) begin
      send_word(8'hE2);
      send_word(8'h96);
      send_word(8'h88);
      repeat (6) send_word(8'($urandom_range(0, 255)));
      send_point(map_pts[$urandom_range(0, MapSize - 1)], 3);
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    in_byte    <= 8'h00;
    acc_point  = '0;
    need_cnt   = 2'd0;
    taken_cnt  = 2'd0;
    err_count  = 0;
    items_sent = 0;
    hold_left  = 0;
    stall_left = 0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_text_stream(190, 1'b1);
    test_noise(40);
    test_backpressure();
    test_text_stream(60, 1'b0);   // a stretch with no idling on either side
    test_drain_pause();
    test_noise(20);

    // let the tail drain, then give the block a few more cycles
    wait_drained();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (DrainCycles) @(posedge clk);

    if (err_count == 0) begin
      $display("** utf8_to_cp437_converter_unit: PASSED **");
    end else begin
      $display("** utf8_to_cp437_converter_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/u2c_pkg.sv
rtl/u2c_front.sv
rtl/u2c_queue.sv
rtl/u2c_back.sv
rtl/utf8_to_cp437_converter_unit.sv
dv/utf8_to_cp437_converter_unit_tb.sv
